// ===== sv/rational_arithmetic_unit_top_macros.svh =====
// Assertion macros shared by the rational arithmetic unit.
// RAU_ASSERT checks a property while reset is released.
// RAU_ASSERT_ALWAYS checks a property at every clock edge.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define RAU_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RAU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(name, clk, rstn, prop, msg)
`define RAU_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== sv/rau_pkg.sv =====
`timescale 1ns / 1ps

package rau_pkg;

  // Default operand width.
  localparam int unsigned RAU_OPERAND_WIDTH = 32;

  // Width of the internal products and of the GCD and divider datapaths.
  localparam int unsigned RAU_WORD_W = 64;

  // Width of one multiplier operand: the widest operand plus a sign bit.
  localparam int unsigned RAU_MUL_W = 33;

  // Operation codes.
  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_CMP = 3'd4;

  // Status of an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rau_unit_sts_t;

endpackage

// ===== sv/rau_gcd.sv =====
`timescale 1ns / 1ps

module rau_gcd (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rau_pkg::RAU_WORD_W-1:0]     x_i,
  input  logic [rau_pkg::RAU_WORD_W-1:0]     y_i,
  output rau_pkg::rau_unit_sts_t             sts_o,
  output logic [rau_pkg::RAU_WORD_W-1:0]     g_o
);
  import rau_pkg::*;

  localparam int unsigned KW = $clog2(RAU_WORD_W) + 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [RAU_WORD_W-1:0] x_q, x_d;
  logic [RAU_WORD_W-1:0] y_q, y_d;
  logic [KW-1:0]         k_q, k_d;
  logic [RAU_WORD_W-1:0] g_q, g_d;
  logic [RAU_WORD_W-1:0] diff_xy, diff_yx;
  logic                  x_ge_y;

  // One binary GCD step per cycle, with a subtractor for each order of the operands.
  assign x_ge_y  = (x_q >= y_q);
  assign diff_xy = x_q - y_q;
  assign diff_yx = y_q - x_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    g_d    = g_q;
    if (start_i) begin
      busy_d = 1'b1;
      x_d    = x_i;
      y_d    = y_i;
      k_d    = '0;
    end else if (busy_q) begin
      if ((x_q == '0) || (y_q == '0)) begin
        g_d    = (x_q | y_q) << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        case ({x_q[0], y_q[0]})
          2'b00: begin
            x_d = x_q >> 1;
            y_d = y_q >> 1;
            k_d = k_q + KW'(1);
          end
          2'b01: begin
            x_d = x_q >> 1;
          end
          2'b10: begin
            y_d = y_q >> 1;
          end
          default: begin
            if (x_ge_y) begin
              x_d = diff_xy >> 1;
            end else begin
              y_d = diff_yx >> 1;
            end
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign g_o        = g_q;

endmodule

// ===== sv/rau_div.sv =====
`timescale 1ns / 1ps

module rau_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rau_pkg::RAU_WORD_W-1:0]     dividend_i,
  input  logic [rau_pkg::RAU_WORD_W-1:0]     divisor_i,
  output rau_pkg::rau_unit_sts_t             sts_o,
  output logic [rau_pkg::RAU_WORD_W-1:0]     quotient_o
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(RAU_WORD_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [RAU_WORD_W-1:0] rem_q, rem_d;
  logic [RAU_WORD_W-1:0] quo_q, quo_d;
  logic [RAU_WORD_W-1:0] dsr_q, dsr_d;
  logic [RAU_WORD_W-1:0] rem_sh;
  logic                  fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q[RAU_WORD_W-2:0], quo_q[RAU_WORD_W-1]};
  assign fits   = (rem_sh >= dsr_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - dsr_q) : rem_sh;
      quo_d = {quo_q[RAU_WORD_W-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(RAU_WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/rational_arithmetic_unit_top.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------------
// input    | in_valid_i / in_ready_o | func_i, a_num_i, a_den_i, b_num_i, b_den_i
// output   | out_valid_o/out_ready_i | result_num_o, result_den_o, compare_sign_o,
//          |                         | status_o
//
// One transaction at a time: error and unused-code cases go straight to the done state, compare
// ends after the three products and the combine step, and arithmetic runs the binary GCD loop
// (one step a cycle) and then two restoring divisions on the shared divider.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A finished result waits in the output register while a new transaction is taken;
// a stalled output holds the sequencer in its final state.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_top_macros.svh"

module rational_arithmetic_unit_top #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               func_i,
  input  logic [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-2:0] a_den_i,
  input  logic [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-2:0] b_den_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [63:0]              result_num_o,
  output logic [62:0]              result_den_o,
  output logic [1:0]               compare_sign_o,
  output logic                     status_o
);
  import rau_pkg::*;

  localparam int unsigned SW = 4;
  localparam logic [SW-1:0] ST_IDLE  = 4'd0;
  localparam logic [SW-1:0] ST_MUL0  = 4'd1;
  localparam logic [SW-1:0] ST_MUL1  = 4'd2;
  localparam logic [SW-1:0] ST_MUL2  = 4'd3;
  localparam logic [SW-1:0] ST_COMB  = 4'd4;
  localparam logic [SW-1:0] ST_SIGN  = 4'd5;
  localparam logic [SW-1:0] ST_GCD   = 4'd6;
  localparam logic [SW-1:0] ST_DIV0  = 4'd7;
  localparam logic [SW-1:0] ST_DIV0W = 4'd8;
  localparam logic [SW-1:0] ST_DIV1  = 4'd9;
  localparam logic [SW-1:0] ST_DIV1W = 4'd10;
  localparam logic [SW-1:0] ST_DONE  = 4'd11;

  localparam int unsigned PW = 2 * RAU_MUL_W;

  logic [SW-1:0]         state_q, state_d;
  logic [2:0]            func_q;
  logic [RAU_MUL_W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic [RAU_WORD_W-1:0] p1_q, p2_q, p3_q;
  logic [RAU_WORD_W-1:0] n_q, n_d, d_q, d_d;
  logic [RAU_WORD_W-1:0] mag_q, mag_d;
  logic                  neg_q;
  logic [RAU_WORD_W-1:0] g_q, q1_q;
  logic [RAU_WORD_W-1:0] diff;
  logic [RAU_MUL_W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod;
  logic                  in_fire;
  logic                  in_err;

  // Staged result and output register.
  logic [63:0] rnum_q, rnum_d;
  logic [62:0] rden_q, rden_d;
  logic [1:0]  csign_q, csign_d;
  logic        stat_q, stat_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] onum_q;
  logic [62:0] oden_q;
  logic [1:0]  ocsign_q;
  logic        ostat_q;
  logic        out_load;

  // Shared iterative units.
  rau_unit_sts_t         gcd_sts, div_sts;
  logic                  gcd_start, div_start;
  logic [RAU_WORD_W-1:0] gcd_g, div_dividend, div_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_err     = (a_den_i == '0) || (b_den_i == '0) ||
                      ((func_i == FUNC_DIV) && (b_num_i == '0));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = ad_q;
    mul_b = bd_q;
    case (state_q)
      ST_MUL0: begin
        mul_a = an_q;
        mul_b = (func_q == FUNC_MUL) ? bn_q : bd_q;
      end
      ST_MUL1: begin
        mul_a = ad_q;
        mul_b = (func_q == FUNC_MUL) ? bd_q : bn_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = $signed(mul_a) * $signed(mul_b);

  // Numerator and denominator before reduction.
  assign diff = p1_q - p2_q;

  always_comb begin
    n_d = p1_q;
    d_d = p2_q;
    case (func_q)
      FUNC_ADD: begin
        n_d = p1_q + p2_q;
        d_d = p3_q;
      end
      FUNC_SUB: begin
        n_d = diff;
        d_d = p3_q;
      end
      FUNC_DIV: begin
        n_d = p2_q[RAU_WORD_W-1] ? (RAU_WORD_W'(0) - p1_q) : p1_q;
        d_d = p2_q[RAU_WORD_W-1] ? (RAU_WORD_W'(0) - p2_q) : p2_q;
      end
      default: begin
        n_d = p1_q;
        d_d = p2_q;
      end
    endcase
  end

  assign mag_d = n_q[RAU_WORD_W-1] ? (RAU_WORD_W'(0) - n_q) : n_q;

  assign gcd_start    = (state_q == ST_SIGN);
  assign div_start    = (state_q == ST_DIV0) || (state_q == ST_DIV1);
  assign div_dividend = (state_q == ST_DIV0) ? mag_q : d_q;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (mag_d),
    .y_i     (d_q),
    .sts_o   (gcd_sts),
    .g_o     (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (g_q),
    .sts_o      (div_sts),
    .quotient_o (div_q)
  );

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer and staged result.
  always_comb begin
    state_d = state_q;
    rnum_d  = rnum_q;
    rden_d  = rden_q;
    csign_d = csign_q;
    stat_d  = stat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rnum_d  = '0;
          rden_d  = '0;
          csign_d = '0;
          stat_d  = in_err;
          if (in_err || (func_i > FUNC_CMP)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL0;
          end
        end
      end
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_COMB;
      ST_COMB: begin
        if (func_q == FUNC_CMP) begin
          csign_d = (diff == '0) ? 2'b00 : (diff[RAU_WORD_W-1] ? 2'b11 : 2'b01);
          state_d = ST_DONE;
        end else begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: state_d = ST_GCD;
      ST_GCD: begin
        if (gcd_sts.done) begin
          state_d = ST_DIV0;
        end
      end
      ST_DIV0: state_d = ST_DIV0W;
      ST_DIV0W: begin
        if (div_sts.done) begin
          state_d = ST_DIV1;
        end
      end
      ST_DIV1: state_d = ST_DIV1W;
      ST_DIV1W: begin
        if (div_sts.done) begin
          rnum_d  = neg_q ? (64'd0 - q1_q) : q1_q;
          rden_d  = div_q[62:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid follows the load and the downstream handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operand capture, products and intermediate values.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      an_q   <= {{(RAU_MUL_W - OPERAND_WIDTH){a_num_i[OPERAND_WIDTH-1]}}, a_num_i};
      bn_q   <= {{(RAU_MUL_W - OPERAND_WIDTH){b_num_i[OPERAND_WIDTH-1]}}, b_num_i};
      ad_q   <= {{(RAU_MUL_W - OPERAND_WIDTH + 1){1'b0}}, a_den_i};
      bd_q   <= {{(RAU_MUL_W - OPERAND_WIDTH + 1){1'b0}}, b_den_i};
    end
    if (state_q == ST_MUL0) begin
      p1_q <= prod[RAU_WORD_W-1:0];
    end
    if (state_q == ST_MUL1) begin
      p2_q <= prod[RAU_WORD_W-1:0];
    end
    if (state_q == ST_MUL2) begin
      p3_q <= prod[RAU_WORD_W-1:0];
    end
    if (state_q == ST_COMB) begin
      n_q <= n_d;
      d_q <= d_d;
    end
    if (state_q == ST_SIGN) begin
      neg_q <= n_q[RAU_WORD_W-1];
      mag_q <= mag_d;
    end
    if (gcd_sts.done) begin
      g_q <= gcd_g;
    end
    if ((state_q == ST_DIV0W) && div_sts.done) begin
      q1_q <= div_q;
    end
    rnum_q  <= rnum_d;
    rden_q  <= rden_d;
    csign_q <= csign_d;
    stat_q  <= stat_d;
    if (out_load) begin
      onum_q   <= rnum_q;
      oden_q   <= rden_q;
      ocsign_q <= csign_q;
      ostat_q  <= stat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_num_o   = onum_q;
  assign result_den_o   = oden_q;
  assign compare_sign_o = ocsign_q;
  assign status_o       = ostat_q;

  // An error transaction carries nothing but its status.
  `RAU_ASSERT(a_err_clean, clk_i, rst_ni, (out_valid_o && status_o) |-> ((result_num_o == '0) && (result_den_o == '0) && (compare_sign_o == '0)), "error result has nonzero fields")
  // A nonzero compare sign never comes with a fraction.
  `RAU_ASSERT(a_cmp_no_frac, clk_i, rst_ni, (out_valid_o && (compare_sign_o != '0)) |-> ((result_den_o == '0) && (result_num_o == '0)), "compare result carries a fraction")
  // The denominator is never zero, so the GCD is never zero.
  `RAU_ASSERT(a_gcd_nonzero, clk_i, rst_ni, gcd_sts.done |-> (gcd_g != '0), "zero GCD")
  // The combine step always follows the last multiplication.
  `RAU_ASSERT(a_comb_order, clk_i, rst_ni, (state_q == ST_COMB) |-> ($past(state_q) == ST_MUL2), "combine step out of order")

endmodule

// ===== sim/rau_result_checker.sv =====
`timescale 1ns / 1ps

module rau_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  func_i,
  input  logic [31:0] a_num_i,
  input  logic [30:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [30:0] b_den_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] result_num_i,
  input  logic [62:0] result_den_i,
  input  logic [1:0]  compare_sign_i,
  input  logic        status_i,
  output int          error_count_o,
  output int          pending_o
);
  import rau_pkg::*;

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  sgn;
    logic        sts;
  } fraction_result_t;

  fraction_result_t expected_results[$];

  // Euclid's algorithm on unsigned 64-bit values.
  function automatic logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Exact fraction arithmetic with sign moved to the numerator, then reduction.
  function automatic fraction_result_t compute_fraction(
      logic [2:0] op, logic [31:0] an32, logic [30:0] ad31,
      logic [31:0] bn32, logic [30:0] bd31);
    fraction_result_t r;
    logic [63:0] an, ad, bn, bd, n, d, mag, g, diff;
    logic neg;
    r = '0;
    an = {{32{an32[31]}}, an32};
    bn = {{32{bn32[31]}}, bn32};
    ad = {33'd0, ad31};
    bd = {33'd0, bd31};
    if (ad == 0 || bd == 0) begin
      r.sts = 1'b1;
      return r;
    end
    case (op)
      FUNC_ADD: begin
        n = an * bd + ad * bn;
        d = ad * bd;
      end
      FUNC_SUB: begin
        n = an * bd - ad * bn;
        d = ad * bd;
      end
      FUNC_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      FUNC_DIV: begin
        if (bn == 0) begin
          r.sts = 1'b1;
          return r;
        end
        n = an * bd;
        d = ad * bn;
        if (d[63]) begin
          n = -n;
          d = -d;
        end
      end
      FUNC_CMP: begin
        diff = an * bd - bn * ad;
        r.sgn = (diff == 0) ? 2'd0 : (diff[63] ? 2'd3 : 2'd1);
        return r;
      end
      default: return r;
    endcase
    neg = n[63];
    mag = neg ? -n : n;
    g = common_divisor(mag, d);
    if (g != 0) begin
      mag = mag / g;
      d = d / g;
    end
    r.num = neg ? -mag : mag;
    r.den = d[62:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    error_count_o++;
  endtask

  initial error_count_o = 0;
  assign pending_o = expected_results.size();

  // Predict on each accepted input transaction, compare each accepted output one.
  always @(posedge clk_i) begin
    fraction_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_results.push_back(
          compute_fraction(func_i, a_num_i, a_den_i, b_num_i, b_den_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result_num_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (result_num_i !== want.num) report_mismatch("result_num", result_num_i, want.num);
          if (result_den_i !== want.den) report_mismatch("result_den", result_den_i, want.den);
          if (compare_sign_i !== want.sgn)
            report_mismatch("compare_sign", compare_sign_i, want.sgn);
          if (status_i !== want.sts) report_mismatch("status", status_i, want.sts);
        end
      end
    end
  end

endmodule

// ===== sim/rational_arithmetic_unit_top_test.sv =====
`timescale 1ns / 1ps

module rational_arithmetic_unit_top_test;
  import rau_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = '0;
  logic [31:0] a_num_i = '0;
  logic [30:0] a_den_i = 31'd1;
  logic [31:0] b_num_i = '0;
  logic [30:0] b_den_i = 31'd1;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_num_o;
  logic [62:0] result_den_o;
  logic [1:0]  compare_sign_o;
  logic        status_o;
  int          error_count;
  int          pending;
  int          cycle_count = 0;
  bit          calm_phase = 1'b0;
  bit          hold_output = 1'b0;
  bit          stimulus_done = 1'b0;

  localparam int CYCLE_LIMIT = 2000000;

  rational_arithmetic_unit_top u_dut (.*);

  rau_result_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .out_valid_i(out_valid_o), .out_ready_i, .result_num_i(result_num_o),
    .result_den_i(result_den_o), .compare_sign_i(compare_sign_o), .status_i(status_o),
    .error_count_o(error_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver readiness: random stalls, none in the calm phase, stalled throughout a hold-off.
  always @(negedge clk_i) begin
    if (hold_output) out_ready_i <= 1'b0;
    else if (calm_phase) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 24);
  end

  // Picks a numerator with frequent extremes and small values.
  function automatic logic [31:0] pick_numerator();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3, 4: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_denominator();
    case ($urandom_range(7))
      0: return 31'h7fff_ffff;
      1: return 31'd1;
      2: return 31'd0;
      3, 4: return 31'($urandom_range(12, 1));
      default: return 31'($urandom);
    endcase
  endfunction

  // Offers one input transaction and waits until it is accepted.
  task automatic send_operands(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
                               logic [31:0] bn, logic [30:0] bd);
    while (!calm_phase && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [2:0] op;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every operation at the extremes, division by zero, bad codes.
    for (int k = 0; k < 5; k++) begin
      send_operands(3'(k), 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'h7fff_ffff);
      send_operands(3'(k), 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'd1);
      send_operands(3'(k), 32'd6, 31'd4, 32'hffff_fffd, 31'd2);
    end
    send_operands(FUNC_DIV, 32'd5, 31'd3, 32'd0, 31'd7);
    send_operands(FUNC_ADD, 32'd0, 31'd5, 32'd0, 31'd9);
    send_operands(FUNC_MUL, 32'd3, 31'd0, 32'd2, 31'd1);
    send_operands(FUNC_CMP, 32'd1, 31'd1, 32'd2, 31'd0);
    send_operands(FUNC_CMP, 32'd2, 31'd4, 32'd1, 31'd2);
    send_operands(3'd5, 32'd1, 31'd1, 32'd1, 31'd1);
    send_operands(3'd6, 32'd1, 31'd1, 32'd1, 31'd1);
    send_operands(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);

    // Random: mostly valid codes, a long calm stretch, and one receiver hold-off.
    for (int n = 0; n < 1650; n++) begin
      calm_phase = (n >= 400 && n < 600);
      if (n == 900) begin
        fork
          begin
            hold_output = 1'b1;
            repeat (1500) @(negedge clk_i);
            hold_output = 1'b0;
          end
        join_none
      end
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_operands(op, pick_numerator(), pick_denominator(), pick_numerator(),
                    pick_denominator());
    end
    in_valid_i <= 1'b0;
    calm_phase = 1'b0;
    stimulus_done = 1'b1;

    while (pending != 0 || hold_output) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
